// ----- src/tcq_pkg.sv -----
package tcq_pkg;

  localparam int unsigned SAMPLE_BITS = 10;
  localparam int unsigned CFG_W       = 10;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned RUN_W       = 11;

  localparam logic [RUN_W-1:0] RUN_LIMIT = RUN_W'(1000);
  localparam logic [RUN_W-1:0] RUN_CAP   = RUN_W'(1001);

  localparam logic [CFG_W-1:0] WHITE_BELOW_RST    = CFG_W'(220);
  localparam logic [CFG_W-1:0] RED_ABOVE_RST      = CFG_W'(260);
  localparam logic [CFG_W-1:0] RED_BELOW_RST      = CFG_W'(315);
  localparam logic [CFG_W-1:0] GREEN_ABOVE_RST    = CFG_W'(350);
  localparam logic [CFG_W-1:0] GREEN_BELOW_RST    = CFG_W'(440);
  localparam logic [CFG_W-1:0] BLACK_ABOVE_RST    = CFG_W'(460);
  localparam logic [CFG_W-1:0] STABLE_SAMPLES_RST = CFG_W'(400);

  // Width of 9 * sample.
  localparam int unsigned PROD_W = SAMPLE_BITS + 4;

  // Division by ten as a multiplication by a rounded-up reciprocal. With the
  // shift four bits above the dividend width the rounding error stays below
  // one quotient step for every dividend of PROD_W bits.
  localparam int unsigned DIV_K    = PROD_W + 4;
  localparam int unsigned DIV_M_W  = DIV_K - 3;
  localparam int unsigned DIV_P_W  = PROD_W + DIV_M_W;
  localparam logic [DIV_M_W-1:0] DIV_M =
    DIV_M_W'(((64'd1 << DIV_K) + 64'd9) / 64'd10);

  typedef enum logic [1:0] {
    COL_WHITE = 2'd0,
    COL_RED   = 2'd1,
    COL_GREEN = 2'd2,
    COL_BLACK = 2'd3
  } colour_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WHITE_BELOW    = 3'd0,
    REG_RED_ABOVE      = 3'd1,
    REG_RED_BELOW      = 3'd2,
    REG_GREEN_ABOVE    = 3'd3,
    REG_GREEN_BELOW    = 3'd4,
    REG_BLACK_ABOVE    = 3'd5,
    REG_STABLE_SAMPLES = 3'd6
  } cfg_reg_t;

  function automatic logic [SAMPLE_BITS-1:0] div10(input logic [PROD_W-1:0] x);
    logic [DIV_P_W-1:0] p;
    p = DIV_P_W'(x) * DIV_P_W'(DIV_M);
    return p[DIV_K +: SAMPLE_BITS];
  endfunction

endpackage

// ----- src/tape_color_qualifier_top.sv -----
// An accepted sample is held in the first stage with its share of the level;
// when that stage is processed, an emitted result goes to the output register.
// Throughput: one sample per cycle; the input stalls only while a stalled
// result is held in the output register and the held sample would emit another.
// The colour loop (level divide by ten, band compares, run count) is
// combinational. Synchronous active-low reset restores the register defaults,
// clears the smoothed level and run count, sets white and empties both stages.
module tape_color_qualifier_top
  import tcq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_colour,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  logic [CFG_W-1:0] white_below_r;
  logic [CFG_W-1:0] red_above_r;
  logic [CFG_W-1:0] red_below_r;
  logic [CFG_W-1:0] green_above_r;
  logic [CFG_W-1:0] green_below_r;
  logic [CFG_W-1:0] black_above_r;
  logic [CFG_W-1:0] stable_samples_r;

  logic                   vld_r;
  logic [SAMPLE_BITS-1:0] part_r;

  logic [SAMPLE_BITS-1:0] level_r;
  logic [SAMPLE_BITS-1:0] level_nxt;
  colour_t                colour_r;
  colour_t                colour_nxt;
  logic [RUN_W-1:0]       run_r;
  logic [RUN_W-1:0]       run_nxt;
  logic [RUN_W-1:0]       run_inc;
  logic                   changed;
  logic                   emit;

  logic                   out_vld_r;
  colour_t                out_colour_r;

  logic in_acc;
  logic out_free;
  logic proc_go;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      white_below_r    <= WHITE_BELOW_RST;
      red_above_r      <= RED_ABOVE_RST;
      red_below_r      <= RED_BELOW_RST;
      green_above_r    <= GREEN_ABOVE_RST;
      green_below_r    <= GREEN_BELOW_RST;
      black_above_r    <= BLACK_ABOVE_RST;
      stable_samples_r <= STABLE_SAMPLES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WHITE_BELOW:    white_below_r    <= cfg_data;
        REG_RED_ABOVE:      red_above_r      <= cfg_data;
        REG_RED_BELOW:      red_below_r      <= cfg_data;
        REG_GREEN_ABOVE:    green_above_r    <= cfg_data;
        REG_GREEN_BELOW:    green_below_r    <= cfg_data;
        REG_BLACK_ABOVE:    black_above_r    <= cfg_data;
        REG_STABLE_SAMPLES: stable_samples_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_free = !out_vld_r || !out_stall;
  assign proc_go  = vld_r && (!emit || out_free);
  assign in_stall = vld_r && !proc_go;
  assign in_acc   = in_valid && !in_stall;

  // The sample's share of the new level does not depend on state, so it is
  // formed while the transaction is taken in.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_acc) begin
      vld_r <= 1'b1;
    end else if (proc_go) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      part_r <= div10(PROD_W'(in_sample) * PROD_W'(9));
    end
  end

  always_comb begin
    level_nxt  = part_r + div10(PROD_W'(level_r));
    colour_nxt = colour_r;
    changed    = 1'b0;
    if (colour_nxt != COL_WHITE && level_nxt < white_below_r) begin
      colour_nxt = COL_WHITE;
      changed    = 1'b1;
    end
    if (colour_nxt != COL_RED && level_nxt > red_above_r && level_nxt < red_below_r) begin
      colour_nxt = COL_RED;
      changed    = 1'b1;
    end
    if (colour_nxt != COL_GREEN && level_nxt > green_above_r
        && level_nxt < green_below_r) begin
      colour_nxt = COL_GREEN;
      changed    = 1'b1;
    end
    if (colour_nxt != COL_BLACK && level_nxt > black_above_r) begin
      colour_nxt = COL_BLACK;
      changed    = 1'b1;
    end
    run_inc = changed ? '0 : run_r + RUN_W'(1);
    emit    = (run_inc == RUN_W'(stable_samples_r));
    run_nxt = (run_inc > RUN_LIMIT) ? RUN_CAP : run_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= '0;
      colour_r <= COL_WHITE;
      run_r    <= '0;
    end else if (proc_go) begin
      level_r  <= level_nxt;
      colour_r <= colour_nxt;
      run_r    <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc_go && emit) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && emit) begin
      out_colour_r <= colour_nxt;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_colour = out_colour_r;

endmodule

// ----- src/tcq_checker.sv -----
module tcq_checker
  import tcq_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [1:0]             out_colour
);

  // A result waiting on a stalled output stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_colour))
    else $error("stalled colour changed");

  // The input only backs up behind a result that cannot leave.
  a_stall_cause: assert property (@(posedge clk)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind tape_color_qualifier_top tcq_checker u_tcq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_colour (out_colour)
);
